### design/stepper_trapezoid_ramp_top_assert.svh
// Assertion macros for the trapezoid step generator.
// Taken in by the top level; no other dependencies.
`ifndef STEPPER_TRAPEZOID_RAMP_TOP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SRAMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SRAMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sramp_pkg.sv
// Shared types and constants for the trapezoid step generator.
// No dependencies.
`default_nettype none

package sramp_pkg;

	localparam int STEP_W = 16;          // step counts and ramp lengths
	localparam int K2_W   = 40;          // ramp_k2 register
	localparam int PROD_W = STEP_W + K2_W; // l * ramp_k2
	localparam int SQ_W   = PROD_W / 2;  // root width
	localparam int REM_W  = SQ_W + 2;    // root remainder
	localparam int CNT_W  = $clog2(SQ_W);
	localparam int IN_W   = 24;          // input tdata, byte padded
	localparam int OUT_W  = 24;          // output tdata, byte padded

	// register indexes
	localparam logic REG_RAMP_K2  = 1'b0;
	localparam logic REG_MAX_RAMP = 1'b1;

	// item kinds on s_tuser
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// move phases
	localparam logic [1:0] PH_STOP   = 2'd0;
	localparam logic [1:0] PH_ACCEL  = 2'd1;
	localparam logic [1:0] PH_CRUISE = 2'd2;
	localparam logic [1:0] PH_DECEL  = 2'd3;

	localparam logic [STEP_W-1:0] MAX_RAMP_RESET = 16'd50;

	typedef struct packed {
		logic              busy_res;
		logic [STEP_W-1:0] interval_count;
		logic              dir_level;
		logic              step_pulse;
	} out_word_t;

endpackage

`default_nettype wire

### design/stepper_trapezoid_ramp_top.sv
// Trapezoid step generator: top level, with its shared root unit and sequencer.
// Depends on sramp_pkg and stepper_trapezoid_ramp_top_assert.svh.
//
// Use: configure ramp_k2 (index 0) and max_ramp_steps (index 1) through the
// write port while idle. Send words on the s_ channel: tuser 0 starts a move
// (step total and direction in tdata), tuser 1 is a timer tick. Every word
// gives exactly one result word on the m_ channel: step pulse, direction
// level, interval to the next step in timer counts, and whether the move is
// still running.
// Sequence: a start word or a tick while stopped goes straight to the finish
// state; a cruise tick passes the advance state first. A ramp tick makes two
// passes, each a 16 x 40 multiply and 28 root steps (two bits a step through a
// single compare-and-subtract unit), then a difference step, then phase
// update and output load. s_tready is high only while the sequencer is idle, so
// a new word is taken only once the previous one has left the sequencer.
// The result register parts the two sides: a new word is taken while the last
// result still waits; a finished result then holds in the sequencer until the
// receiver takes the previous one.
// Reset: stopped, registers ramp_k2 = 0 and max_ramp_steps = 50, no result.
`default_nettype none
`include "stepper_trapezoid_ramp_top_assert.svh"

module stepper_trapezoid_ramp_top
	import sramp_pkg::*;
#(
	parameter int unsigned COUNT_MAX = 65535
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration writes
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [K2_W-1:0]  wr_data,
	// input words
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // [15:0] step_total, [16] direction, zero pad
	input  wire logic             s_tuser,   // [0] func
	// result words
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // [0] step_pulse, [1] dir_level,
	                                          // [17:2] interval_count, [18] busy_res, zero pad
);

	// interval storage follows the saturation limit, never below the port width
	localparam int IW = $clog2(longint'(COUNT_MAX) + 64'd1);
	localparam int LW = (IW > STEP_W) ? IW : STEP_W;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SQRT = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_ADV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// configuration
	logic [K2_W-1:0]   ramp_k2_q;
	logic [STEP_W-1:0] max_ramp_q;

	// move state
	logic [1:0]        phase_q;
	logic [STEP_W-1:0] step_index_q;
	logic [STEP_W-1:0] move_total_q;
	logic [STEP_W-1:0] ramp_length_q;
	logic [LW-1:0]     last_interval_q;
	logic              move_dir_q;

	// sequencer and root unit
	logic [2:0]        st_q;
	logic              pulse_q;
	logic              pass_q;
	logic [STEP_W-1:0] l_q;
	logic [SQ_W-1:0]   t_hi_q;
	logic [PROD_W-1:0] sq_val_q;
	logic [REM_W-1:0]  sq_rem_q;
	logic [SQ_W-1:0]   sq_root_q;
	logic [CNT_W-1:0]  sq_cnt_q;

	// result register
	logic              m_tvalid_q;
	out_word_t         out_q;

	// input fields
	logic [STEP_W-1:0] in_total;
	logic              in_dir;
	logic              s_accept;
	assign in_total = s_tdata[STEP_W-1:0];
	assign in_dir   = s_tdata[STEP_W];
	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE);

	// a finished word moves into the result register once that register is free
	logic fin_load;
	assign fin_load = (st_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// start: ramp is the smaller of half the total and the configured maximum
	logic [STEP_W-1:0] half_total;
	logic [STEP_W-1:0] ramp_c;
	assign half_total = in_total >> 1;
	assign ramp_c     = (half_total < max_ramp_q) ? half_total : max_ramp_q;

	// multiply l or l-1 by ramp_k2; registered before the root steps
	logic [STEP_W-1:0] mul_l;
	logic [PROD_W-1:0] prod_c;
	assign mul_l  = pass_q ? (l_q - STEP_W'(1)) : l_q;
	assign prod_c = PROD_W'(mul_l) * PROD_W'(ramp_k2_q);

	// one restoring root step: two radicand bits in, one root bit out
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             sq_ge;
	logic [REM_W+1:0] rem_sub;
	logic [SQ_W-1:0]  root_n;
	assign rem_sh  = {sq_rem_q, sq_val_q[PROD_W-1 -: 2]};
	assign trial   = (REM_W+2)'({sq_root_q, 2'b01});
	assign sq_ge   = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;
	assign root_n  = {sq_root_q[SQ_W-2:0], sq_ge};

	// gap and saturation
	logic [SQ_W-1:0] gap_c;
	logic            gap_sat;
	assign gap_c   = t_hi_q - sq_root_q;
	assign gap_sat = (33'(gap_c) > 33'(COUNT_MAX));

	// phase after this step
	logic [STEP_W-1:0] idx_n;
	logic [1:0]        phase_n;
	assign idx_n = step_index_q + STEP_W'(1);
	always_comb begin
		if (idx_n < ramp_length_q) begin
			phase_n = PH_ACCEL;
		end else if (idx_n < (move_total_q - ramp_length_q)) begin
			phase_n = PH_CRUISE;
		end else if (idx_n < move_total_q) begin
			phase_n = PH_DECEL;
		end else begin
			phase_n = PH_STOP;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_k2_q  <= '0;
			max_ramp_q <= MAX_RAMP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_RAMP_K2:  ramp_k2_q  <= wr_data;
				REG_MAX_RAMP: max_ramp_q <= wr_data[STEP_W-1:0];
				default:      ;
			endcase
		end
	end

	// sequencer, move state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= ST_IDLE;
			phase_q         <= PH_STOP;
			step_index_q    <= '0;
			move_total_q    <= '0;
			ramp_length_q   <= '0;
			last_interval_q <= '0;
			move_dir_q      <= 1'b0;
			pulse_q         <= 1'b0;
			pass_q          <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			// load a finished word, or drop the result once taken
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (s_tuser == FUNC_START) begin
							move_dir_q    <= in_dir;
							move_total_q  <= in_total;
							ramp_length_q <= ramp_c;
							step_index_q  <= '0;
							phase_q       <= (in_total == '0) ? PH_STOP : PH_ACCEL;
							pulse_q       <= 1'b0;
							st_q          <= ST_FIN;
						end else if (phase_q == PH_STOP) begin
							pulse_q <= 1'b0;
							st_q    <= ST_FIN;
						end else begin
							pulse_q <= 1'b1;
							pass_q  <= 1'b0;
							// ramp index: next step up, or steps left counting this one
							l_q     <= (phase_q == PH_DECEL) ? (move_total_q - step_index_q)
							                                  : idx_n;
							st_q    <= (phase_q == PH_CRUISE) ? ST_ADV : ST_MUL;
						end
					end
				end
				ST_MUL: begin
					st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_cnt_q == '0) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							st_q   <= ST_MUL;
						end else begin
							st_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					last_interval_q <= gap_sat ? LW'(COUNT_MAX) : LW'(gap_c);
					st_q            <= ST_ADV;
				end
				ST_ADV: begin
					step_index_q <= idx_n;
					phase_q      <= phase_n;
					st_q         <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (fin_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// root unit datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_MUL: begin
				sq_val_q  <= prod_c;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				sq_cnt_q  <= CNT_W'(SQ_W - 1);
			end
			ST_SQRT: begin
				sq_val_q  <= {sq_val_q[PROD_W-3:0], 2'b00};
				sq_rem_q  <= sq_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
				sq_root_q <= root_n;
				sq_cnt_q  <= sq_cnt_q - CNT_W'(1);
				if (sq_cnt_q == '0 && !pass_q) begin
					t_hi_q <= root_n;
				end
			end
			default: ;
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_q.step_pulse     <= pulse_q;
			out_q.dir_level      <= move_dir_q;
			out_q.interval_count <= pulse_q ? last_interval_q[STEP_W-1:0] : '0;
			out_q.busy_res       <= (phase_q != PH_STOP);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(out_q);

	// checks
	`SRAMP_ASSERT_NEXT(a_leave_idle, clk, arst_n, s_accept, st_q != ST_IDLE,
		"sequencer stayed idle after taking a word")
	`SRAMP_ASSERT_NOW(a_decel_in_move, clk, arst_n, phase_q == PH_DECEL,
		step_index_q < move_total_q, "deceleration past the end of the move")
	`SRAMP_ASSERT_NOW(a_ramp_fits, clk, arst_n, 1'b1,
		ramp_length_q <= (move_total_q >> 1), "ramp longer than half the move")

endmodule

`default_nettype wire
